// ===== design/rht_pkg.sv =====
package rht_pkg;

  // Operation codes
  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_LOCK   = 3'd1;
  localparam logic [2:0] OP_UNLOCK = 3'd2;
  localparam logic [2:0] OP_FREE   = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_STALE      = 3'd2;
  localparam logic [2:0] ST_NOT_LOCKED = 3'd3;
  localparam logic [2:0] ST_SATURATED  = 3'd4;

  // Fixed field widths and the slots_in_use reset limit
  localparam int OP_W    = 3;
  localparam int SLOT_W  = 4;
  localparam int HID_W   = 32;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 15;
  localparam int TOP_W   = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int SIU_RST_MAX = 16;

  // Pool size, tied to the slot and free count field widths
  localparam int POOL_SLOTS = 16;

  // Decisions of one executed transaction
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              released;
    logic [CNT_W-1:0]  lock_count;
    logic              slot_we;
    logic              push;
    logic              id_adv;
    logic [TOP_W-1:0]  free_top_nxt;
  } exec_ctl_t;

endpackage

// ===== design/refcounted_handle_table.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         start / busy               in_op, in_slot, in_handle_id
// result    out        out_valid (one cycle)      out_status, out_slot, out_id,
//                                                 out_released, out_lock_count,
//                                                 out_free_slots
// config    in/out     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// In each transaction the accept cycle reads the slot entry and the
// free stack top, the next cycle modifies them and writes back what changed.
// The result shows in the cycle after that, while the next transaction is accepted.
// After reset and after each write of slots_in_use, a clearing pass walks
// POOL_SLOTS entries, one per cycle, with busy high.
// The receiver cannot stall; every result is shown for exactly one cycle.
module refcounted_handle_table #(
  parameter int ID_BITS    = 32,
  parameter int LOCK_BITS  = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rht_pkg::OP_W-1:0]     in_op,
  input  logic [rht_pkg::SLOT_W-1:0]   in_slot,
  input  logic [rht_pkg::HID_W-1:0]    in_handle_id,
  output logic                         out_valid,
  output logic [rht_pkg::STAT_W-1:0]   out_status,
  output logic [rht_pkg::SLOT_W-1:0]   out_slot,
  output logic [rht_pkg::HID_W-1:0]    out_id,
  output logic                         out_released,
  output logic [rht_pkg::CNT_W-1:0]    out_lock_count,
  output logic [rht_pkg::TOP_W-1:0]    out_free_slots,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rht_pkg::ADDR_W-1:0]   paddr,
  input  logic [rht_pkg::DATA_W-1:0]   pwdata,
  output logic [rht_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int POOL_SLOTS = rht_pkg::POOL_SLOTS;
  localparam int SW      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int ENTRY_W = 2 + LOCK_BITS + ID_BITS;
  localparam int SIU_RST = (POOL_SLOTS < rht_pkg::SIU_RST_MAX) ? POOL_SLOTS
                                                                : rht_pkg::SIU_RST_MAX;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                        state_r;
  logic [SW-1:0]                 clr_idx_r;
  logic [rht_pkg::TOP_W-1:0]     siu_r;
  logic [rht_pkg::TOP_W-1:0]     free_top_r;
  logic [ID_BITS-1:0]            id_ctr_r;
  logic [rht_pkg::OP_W-1:0]      op_r;
  logic [rht_pkg::SLOT_W-1:0]    slot_r;
  logic [rht_pkg::HID_W-1:0]     hid_r;
  logic                          out_valid_r;
  logic [rht_pkg::STAT_W-1:0]    out_status_r;
  logic [rht_pkg::SLOT_W-1:0]    out_slot_r;
  logic [rht_pkg::HID_W-1:0]     out_id_r;
  logic                          out_released_r;
  logic [rht_pkg::CNT_W-1:0]     out_lock_count_r;
  logic [rht_pkg::TOP_W-1:0]     out_free_slots_r;

  logic                          accept;
  logic                          clearing;
  logic                          executing;
  logic                          cfg_wr;
  logic [rht_pkg::TOP_W-1:0]     cfg_siu;
  logic [SW-1:0]                 clr_val;

  logic [ENTRY_W-1:0]            entry_rd;
  logic [SW-1:0]                 stk_rd;
  rht_pkg::exec_ctl_t            ctl;
  logic [rht_pkg::SLOT_W-1:0]    res_slot;
  logic [rht_pkg::HID_W-1:0]     res_id;
  logic [SW-1:0]                 ex_waddr;
  logic [ENTRY_W-1:0]            ex_wdata;

  logic                          slot_we;
  logic [SW-1:0]                 slot_waddr;
  logic [ENTRY_W-1:0]            slot_wdata;
  logic                          stk_we;
  logic [SW-1:0]                 stk_waddr;
  logic [SW-1:0]                 stk_wdata;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign clearing  = (state_r == S_CLEAR);
  assign executing = (state_r == S_EXEC);

  // Register write decode and clamp of slots_in_use
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign pready = 1'b1;
  assign prdata = rht_pkg::DATA_W'(siu_r);

  always_comb begin
    if (pwdata[rht_pkg::TOP_W-1:0] == '0) begin
      cfg_siu = rht_pkg::TOP_W'(1);
    end else if (int'(pwdata[rht_pkg::TOP_W-1:0]) > POOL_SLOTS) begin
      cfg_siu = rht_pkg::TOP_W'(POOL_SLOTS);
    end else begin
      cfg_siu = pwdata[rht_pkg::TOP_W-1:0];
    end
  end

  // Free stack fill: slots_in_use-1 down to 0 from the bottom
  assign clr_val = (int'(clr_idx_r) < int'(siu_r))
                 ? SW'(int'(siu_r) - 1 - int'(clr_idx_r)) : '0;

  // Memory write muxing between clearing pass and execution
  assign slot_we    = clearing || (executing && ctl.slot_we);
  assign slot_waddr = clearing ? clr_idx_r : ex_waddr;
  assign slot_wdata = clearing ? '0 : ex_wdata;
  assign stk_we     = clearing || (executing && ctl.push);
  assign stk_waddr  = clearing ? clr_idx_r : SW'(free_top_r);
  assign stk_wdata  = clearing ? clr_val : SW'(slot_r);

  rht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (SW'(in_slot)),
    .rdata (entry_rd)
  );

  rht_ram #(
    .WIDTH (SW),
    .DEPTH (POOL_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (SW'(free_top_r - rht_pkg::TOP_W'(1))),
    .rdata (stk_rd)
  );

  rht_exec #(
    .POOL_SLOTS (POOL_SLOTS),
    .ID_BITS    (ID_BITS),
    .LOCK_BITS  (LOCK_BITS)
  ) u_exec (
    .op         (op_r),
    .slot       (slot_r),
    .hid        (hid_r),
    .entry      (entry_rd),
    .stk_top    (stk_rd),
    .free_top   (free_top_r),
    .siu        (siu_r),
    .id_ctr     (id_ctr_r),
    .ctl        (ctl),
    .res_slot   (res_slot),
    .res_id     (res_id),
    .slot_waddr (ex_waddr),
    .slot_wdata (ex_wdata)
  );

  // Sequencer: clear pass, accept, execute and register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      siu_r       <= rht_pkg::TOP_W'(SIU_RST);
      free_top_r  <= rht_pkg::TOP_W'(SIU_RST);
      id_ctr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + SW'(1);
          if (clr_idx_r == SW'(POOL_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_op;
            slot_r  <= in_slot;
            hid_r   <= in_handle_id;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          free_top_r       <= ctl.free_top_nxt;
          if (ctl.id_adv) begin
            id_ctr_r <= id_ctr_r + ID_BITS'(1);
          end
          out_valid_r      <= 1'b1;
          out_status_r     <= ctl.status;
          out_slot_r       <= res_slot;
          out_id_r         <= res_id;
          out_released_r   <= ctl.released;
          out_lock_count_r <= ctl.lock_count;
          out_free_slots_r <= ctl.free_top_nxt;
          state_r          <= S_IDLE;
        end
        default: begin
          clr_idx_r <= '0;
          state_r   <= S_CLEAR;
        end
      endcase
      // Reinitialize the pool on a register write; the id counter keeps going
      if (cfg_wr) begin
        siu_r      <= cfg_siu;
        free_top_r <= cfg_siu;
        clr_idx_r  <= '0;
        state_r    <= S_CLEAR;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_id         = out_id_r;
  assign out_released   = out_released_r;
  assign out_lock_count = out_lock_count_r;
  assign out_free_slots = out_free_slots_r;

endmodule

// ===== design/rht_ram.sv =====
module rht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/rht_exec.sv =====
module rht_exec #(
  parameter int POOL_SLOTS = 16,
  parameter int ID_BITS    = 32,
  parameter int LOCK_BITS  = 15,
  localparam int SW        = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
  localparam int ENTRY_W   = 2 + LOCK_BITS + ID_BITS
) (
  input  logic [rht_pkg::OP_W-1:0]   op,
  input  logic [rht_pkg::SLOT_W-1:0] slot,
  input  logic [rht_pkg::HID_W-1:0]  hid,
  input  logic [ENTRY_W-1:0]         entry,
  input  logic [SW-1:0]              stk_top,
  input  logic [rht_pkg::TOP_W-1:0]  free_top,
  input  logic [rht_pkg::TOP_W-1:0]  siu,
  input  logic [ID_BITS-1:0]         id_ctr,
  output rht_pkg::exec_ctl_t         ctl,
  output logic [rht_pkg::SLOT_W-1:0] res_slot,
  output logic [rht_pkg::HID_W-1:0]  res_id,
  output logic [SW-1:0]              slot_waddr,
  output logic [ENTRY_W-1:0]         slot_wdata
);

  localparam logic [LOCK_BITS-1:0] LOCK_MAX = {LOCK_BITS{1'b1}};

  logic                 e_live;
  logic                 e_pend;
  logic [LOCK_BITS-1:0] e_lock;
  logic [ID_BITS-1:0]   e_id;
  logic                 in_rng;
  logic                 match;

  assign e_live = entry[ENTRY_W-1];
  assign e_pend = entry[ENTRY_W-2];
  assign e_lock = entry[ID_BITS +: LOCK_BITS];
  assign e_id   = entry[ID_BITS-1:0];

  // Handle check: slot in range, live, same generation
  assign in_rng = ({1'b0, slot} < siu) && (int'(slot) < POOL_SLOTS);
  assign match  = in_rng && e_live && (e_id == ID_BITS'(hid));

  always_comb begin
    logic [LOCK_BITS-1:0] cnt;
    logic                 rel;
    cnt               = '0;
    rel               = 1'b0;
    ctl               = '0;
    ctl.status        = rht_pkg::ST_OK;
    ctl.free_top_nxt  = free_top;
    res_slot          = slot;
    res_id            = hid;
    slot_waddr        = SW'(slot);
    slot_wdata        = entry;
    case (op)
      rht_pkg::OP_ALLOC: begin
        if (free_top == '0) begin
          ctl.status = rht_pkg::ST_FULL;
          res_slot   = '0;
          res_id     = '0;
        end else begin
          // Pop the free stack and stamp the slot with the next id
          ctl.free_top_nxt = free_top - rht_pkg::TOP_W'(1);
          ctl.slot_we      = 1'b1;
          ctl.id_adv       = 1'b1;
          slot_waddr       = stk_top;
          slot_wdata       = {1'b1, 1'b0, {LOCK_BITS{1'b0}}, id_ctr};
          res_slot         = rht_pkg::SLOT_W'(stk_top);
          res_id           = rht_pkg::HID_W'(id_ctr);
        end
      end
      rht_pkg::OP_LOCK: begin
        if (!match || e_pend) begin
          ctl.status = rht_pkg::ST_STALE;
        end else if (e_lock == LOCK_MAX) begin
          ctl.status = rht_pkg::ST_SATURATED;
          cnt        = e_lock;
        end else begin
          cnt         = e_lock + LOCK_BITS'(1);
          ctl.slot_we = 1'b1;
          slot_wdata  = {e_live, e_pend, cnt, e_id};
        end
      end
      rht_pkg::OP_UNLOCK: begin
        if (!match) begin
          ctl.status = rht_pkg::ST_STALE;
        end else if (e_lock == '0) begin
          ctl.status = rht_pkg::ST_NOT_LOCKED;
        end else begin
          cnt = e_lock - LOCK_BITS'(1);
          if (cnt == '0 && e_pend) begin
            rel = 1'b1;
          end else begin
            ctl.slot_we = 1'b1;
            slot_wdata  = {e_live, e_pend, cnt, e_id};
          end
        end
      end
      rht_pkg::OP_FREE: begin
        if (!match) begin
          ctl.status = rht_pkg::ST_STALE;
        end else if (e_lock != '0) begin
          // Defer the release until the last lock drops
          cnt         = e_lock;
          ctl.slot_we = 1'b1;
          slot_wdata  = {e_live, 1'b1, e_lock, e_id};
        end else begin
          rel = 1'b1;
        end
      end
      rht_pkg::OP_QUERY: begin
        if (!match || e_pend) begin
          ctl.status = rht_pkg::ST_STALE;
        end else begin
          cnt = e_lock;
        end
      end
      default: begin
        ctl.status = rht_pkg::ST_STALE;
      end
    endcase
    // Release: clear the entry and push the slot back
    if (rel) begin
      ctl.released = 1'b1;
      ctl.slot_we  = 1'b1;
      slot_wdata   = '0;
      if (int'(free_top) < POOL_SLOTS) begin
        ctl.push         = 1'b1;
        ctl.free_top_nxt = free_top + rht_pkg::TOP_W'(1);
      end
    end
    ctl.lock_count = rht_pkg::CNT_W'(cnt);
  end

endmodule

// ===== design/rht_checker.sv =====
module rht_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [rht_pkg::STAT_W-1:0]   out_status,
  input logic                         out_released,
  input logic [rht_pkg::CNT_W-1:0]    out_lock_count,
  input logic [rht_pkg::TOP_W-1:0]    out_free_slots
);

  // An accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // Results never come in consecutive cycles
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // A result follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in flight");

  // Pool full only when no slot is free
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == rht_pkg::ST_FULL) |-> (out_free_slots == '0))
    else $error("pool full reported with free slots");

  // A release is a successful step that leaves no locks
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_released) |->
      (out_status == rht_pkg::ST_OK && out_lock_count == '0))
    else $error("release with error status or locks held");

endmodule

bind refcounted_handle_table rht_checker u_rht_checker (.*);
